// ----- rtl/cfp_pkg.sv -----
// Shared types and constants for the command frame parser.
// No dependencies; imported by every module of the block.
package cfp_pkg;

  localparam logic [7:0] MAGIC_A    = 8'hE5;
  localparam logic [7:0] MAGIC_B    = 8'h8F;
  localparam logic [7:0] HEADER_LEN = 8'd5;
  localparam logic [2:0] DATA_BYTES = 3'd4;

  // Command kinds
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_RESET = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_OP    = 2'd1;
  localparam logic [1:0] ST_TRUNCATED = 2'd2;
  localparam logic [1:0] ST_BAD_LEN   = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_READ_CODE  = 2'd0;
  localparam logic [1:0] REG_WRITE_CODE = 2'd1;
  localparam logic [1:0] REG_RESET_CODE = 2'd2;

  typedef enum logic [8:0] {
    PH_HUNT1  = 9'b000000001,
    PH_HUNT2  = 9'b000000010,
    PH_COUNT  = 9'b000000100,
    PH_LEN_LO = 9'b000001000,
    PH_LEN_HI = 9'b000010000,
    PH_OPCODE = 9'b000100000,
    PH_BODY   = 9'b001000000,
    PH_SKIP   = 9'b010000000,
    PH_TRUNC  = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic [7:0] read_code;
    logic [7:0] write_code;
    logic [7:0] reset_code;
  } codes_t;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] frame_bytes_left;
    logic [7:0]  length_low_byte;
    logic [7:0]  commands_owed;
    logic [7:0]  command_counter;
    logic [1:0]  current_kind;
    logic [7:0]  serial_hold;
    logic [7:0]  addr_hold;
    logic [31:0] data_hold;
    logic [2:0]  byte_in_command;
  } parse_state_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  command_kind;
    logic [7:0]  serial_tag;
    logic [7:0]  target_addr;
    logic [31:0] write_data;
    logic [7:0]  command_index;
  } result_t;

endpackage

// ----- rtl/command_frame_parser.sv -----
// Top level of the command frame parser: state and opcode registers, step logic, output buffer.
// Depends on cfp_pkg, cfp_step and cfp_obuf.
//
// Usage:
//   Input channel (in_valid / in_stall / rx_byte) carries one stream byte per word.
//   The parser hunts for E5 8F, reads the command count and 16-bit frame
//   length, then decodes read, write and reset commands. Each completed
//   command, and each error (unknown opcode, truncated frame, bad length),
//   leaves as one word on the output channel (out_valid / out_stall and the
//   result fields). Most bytes produce no word.
//   Results are registered: the whole parse step sits between the state
//   registers and the output register. Throughput: one byte per cycle
//   while in_stall is low.
//   Stall: when the receiver holds out_stall, the next result lands in a
//   skid entry; while that entry is occupied in_stall is raised, so no word
//   is lost. in_stall comes straight from a register.
//   Opcode values are set via cfg_wen/cfg_index/cfg_data; users must do so only while idle.
//   Reset: rst (synchronous) returns the parser to the hunt, clears all
//   state, empties the output and restores opcodes read=0, write=1, reset=2.
module command_frame_parser
  import cfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [1:0]  command_kind,
  output logic [7:0]  serial_tag,
  output logic [7:0]  target_addr,
  output logic [31:0] write_data,
  output logic [7:0]  command_index
);

  codes_t       codes;
  parse_state_t state;
  parse_state_t state_next;
  logic         step_emit;
  result_t      step_res;
  result_t      out_data;
  logic         accept;
  logic         buf_full;

  assign in_stall = buf_full;
  assign accept   = in_valid && !buf_full;

  // Opcode registers
  always_ff @(posedge clk) begin
    if (rst) begin
      codes.read_code  <= 8'd0;
      codes.write_code <= 8'd1;
      codes.reset_code <= 8'd2;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_READ_CODE:  codes.read_code  <= cfg_data;
        REG_WRITE_CODE: codes.write_code <= cfg_data;
        REG_RESET_CODE: codes.reset_code <= cfg_data;
        default:        codes            <= codes;
      endcase
    end
  end

  cfp_step u_step (
    .cur     (state),
    .codes   (codes),
    .rx_byte (rx_byte),
    .nxt     (state_next),
    .emit    (step_emit),
    .res     (step_res)
  );

  // Parser state: advance on every accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{phase: PH_HUNT1, frame_bytes_left: 16'd0, length_low_byte: 8'd0,
                 commands_owed: 8'd0, command_counter: 8'd0, current_kind: KIND_READ,
                 serial_hold: 8'd0, addr_hold: 8'd0, data_hold: 32'd0,
                 byte_in_command: 3'd0};
    end else if (accept) begin
      state <= state_next;
    end
  end

  cfp_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && step_emit),
    .push_data (step_res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign status        = out_data.status;
  assign command_kind  = out_data.command_kind;
  assign serial_tag    = out_data.serial_tag;
  assign target_addr   = out_data.target_addr;
  assign write_data    = out_data.write_data;
  assign command_index = out_data.command_index;

endmodule

// ----- rtl/cfp_step.sv -----
// Next-state and result logic for one stream byte of the frame parser.
// Depends on cfp_pkg.
module cfp_step
  import cfp_pkg::*;
(
  input  parse_state_t cur,
  input  codes_t       codes,
  input  logic [7:0]   rx_byte,
  output parse_state_t nxt,
  output logic         emit,
  output result_t      res
);

  logic [15:0] total;
  logic [15:0] left_dec;
  logic [2:0]  bic_inc;
  logic [2:0]  need;
  logic [7:0]  cnt_inc;
  phase_t      hunt_phase;

  always_comb begin
    total      = {rx_byte, cur.length_low_byte};
    left_dec   = (cur.frame_bytes_left != 16'd0) ? cur.frame_bytes_left - 16'd1
                                                 : cur.frame_bytes_left;
    bic_inc    = cur.byte_in_command + 3'd1;
    cnt_inc    = cur.command_counter + 8'd1;
    hunt_phase = (rx_byte == MAGIC_A) ? PH_HUNT2 : PH_HUNT1;
    if (cur.current_kind == KIND_WRITE) begin
      need = 3'd2 + DATA_BYTES;
    end else if (cur.current_kind == KIND_READ) begin
      need = 3'd2;
    end else begin
      need = 3'd1;
    end

    nxt  = cur;
    emit = 1'b0;
    res  = '0;

    case (cur.phase)
      PH_HUNT1: begin
        nxt.phase = hunt_phase;
      end
      PH_HUNT2: begin
        nxt.phase = (rx_byte == MAGIC_B) ? PH_COUNT : hunt_phase;
      end
      PH_COUNT: begin
        nxt.commands_owed = rx_byte;
        nxt.phase         = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        nxt.length_low_byte = rx_byte;
        nxt.phase           = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        nxt.command_counter = 8'd0;
        if (total < {8'd0, HEADER_LEN}) begin
          nxt.frame_bytes_left = 16'd0;
          nxt.phase            = PH_HUNT1;
          emit                 = 1'b1;
          res.status           = ST_BAD_LEN;
        end else begin
          nxt.frame_bytes_left = total - {8'd0, HEADER_LEN};
          if (cur.commands_owed == 8'd0) begin
            nxt.phase = (total == {8'd0, HEADER_LEN}) ? PH_HUNT1 : PH_SKIP;
          end else if (total == {8'd0, HEADER_LEN}) begin
            nxt.phase  = PH_HUNT1;
            emit       = 1'b1;
            res.status = ST_TRUNCATED;
          end else begin
            nxt.phase = PH_OPCODE;
          end
        end
      end
      PH_OPCODE: begin
        nxt.frame_bytes_left = left_dec;
        if ((rx_byte == codes.read_code) || (rx_byte == codes.write_code) ||
            (rx_byte == codes.reset_code)) begin
          if (rx_byte == codes.read_code) begin
            nxt.current_kind = KIND_READ;
          end else if (rx_byte == codes.write_code) begin
            nxt.current_kind = KIND_WRITE;
          end else begin
            nxt.current_kind = KIND_RESET;
          end
          nxt.byte_in_command = 3'd0;
          nxt.serial_hold     = 8'd0;
          nxt.addr_hold       = 8'd0;
          nxt.data_hold       = 32'd0;
          if (left_dec == 16'd0) begin
            nxt.phase         = PH_HUNT1;
            emit              = 1'b1;
            res.status        = ST_TRUNCATED;
            res.command_index = cur.command_counter;
          end else begin
            nxt.phase = PH_BODY;
          end
        end else begin
          // Unknown opcode: report it and drop the rest of the frame
          nxt.phase         = (left_dec == 16'd0) ? PH_HUNT1 : PH_SKIP;
          emit              = 1'b1;
          res.status        = ST_BAD_OP;
          res.command_index = cur.command_counter;
        end
      end
      PH_BODY: begin
        nxt.frame_bytes_left = left_dec;
        case (cur.byte_in_command)
          3'd0:    nxt.serial_hold       = rx_byte;
          3'd1:    nxt.addr_hold         = rx_byte;
          3'd2:    nxt.data_hold[7:0]    = rx_byte;
          3'd3:    nxt.data_hold[15:8]   = rx_byte;
          3'd4:    nxt.data_hold[23:16]  = rx_byte;
          3'd5:    nxt.data_hold[31:24]  = rx_byte;
          default: nxt.data_hold         = cur.data_hold;
        endcase
        nxt.byte_in_command = bic_inc;
        if (bic_inc >= need) begin
          nxt.command_counter = cnt_inc;
          if (cnt_inc == cur.commands_owed) begin
            nxt.phase = (left_dec == 16'd0) ? PH_HUNT1 : PH_SKIP;
          end else if (left_dec == 16'd0) begin
            nxt.phase = PH_TRUNC;
          end else begin
            nxt.phase = PH_OPCODE;
          end
          emit              = 1'b1;
          res.status        = ST_OK;
          res.command_kind  = cur.current_kind;
          res.serial_tag    = nxt.serial_hold;
          res.command_index = cur.command_counter;
          if (cur.current_kind != KIND_RESET) begin
            res.target_addr = nxt.addr_hold;
          end
          if (cur.current_kind == KIND_WRITE) begin
            res.write_data = nxt.data_hold;
          end
        end else if (left_dec == 16'd0) begin
          nxt.phase         = PH_HUNT1;
          emit              = 1'b1;
          res.status        = ST_TRUNCATED;
          res.command_index = cur.command_counter;
        end
      end
      PH_SKIP: begin
        nxt.frame_bytes_left = left_dec;
        if (left_dec == 16'd0) begin
          nxt.phase = PH_HUNT1;
        end
      end
      PH_TRUNC: begin
        nxt.phase         = hunt_phase;
        emit              = 1'b1;
        res.status        = ST_TRUNCATED;
        res.command_index = cur.command_counter;
      end
      default: begin
        nxt.phase = hunt_phase;
      end
    endcase
  end

endmodule

// ----- rtl/cfp_obuf.sv -----
// Output register with one skid entry for parser result words.
// Depends on cfp_pkg.
module cfp_obuf
  import cfp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  logic    skid_valid;
  result_t skid_data;
  logic    pop;

  assign pop  = out_valid && !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_data  <= push_data;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= push_data;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ----- tb/tb.sv -----
// Self-checking bench for command_frame_parser: directed frames, then random well-formed
// and broken frames under several opcode settings, checked word by word by a scoreboard.
// Depends on cfp_pkg and the command_frame_parser RTL.
module tb;
  import cfp_pkg::*;

  // Stray opcode marker for the frame builder: picks a random opcode byte.
  localparam logic [1:0] KIND_STRAY = 2'd3;

  // Scoreboard: carries its own copy of the parser state and opcode registers,
  // predicts the word (if any) that each accepted byte causes, and matches
  // arriving words against the oldest prediction.
  class frame_scoreboard;
    result_t     expected_words[$];
    codes_t      codes;
    phase_t      ph;
    logic [15:0] bytes_left;
    logic [7:0]  len_lo;
    logic [7:0]  owed;
    logic [7:0]  cmd_count;
    logic [1:0]  kind;
    logic [7:0]  ser;
    logic [7:0]  addr;
    logic [31:0] data;
    logic [2:0]  pos;
    int          errors;
    int          ok_words;
    int          err_words;

    function new();
      codes      = '{read_code: 8'h00, write_code: 8'h01, reset_code: 8'h02};
      ph         = PH_HUNT1;
      bytes_left = '0;
      len_lo     = '0;
      owed       = '0;
      cmd_count  = '0;
      kind       = KIND_READ;
      ser        = '0;
      addr       = '0;
      data       = '0;
      pos        = '0;
      errors     = 0;
      ok_words   = 0;
      err_words  = 0;
    endfunction

    function void set_code(logic [1:0] idx, logic [7:0] v);
      case (idx)
        REG_READ_CODE:  codes.read_code  = v;
        REG_WRITE_CODE: codes.write_code = v;
        REG_RESET_CODE: codes.reset_code = v;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function void push_word(logic [1:0] st, logic [1:0] k, logic [7:0] s, logic [7:0] a,
                            logic [31:0] d, logic [7:0] idx);
      result_t w;
      w.status        = st;
      w.command_kind  = k;
      w.serial_tag    = s;
      w.target_addr   = a;
      w.write_data    = d;
      w.command_index = idx;
      expected_words.push_back(w);
      if (st == ST_OK) ok_words++;
      else err_words++;
    endfunction

    function void push_error(logic [1:0] st, logic [7:0] idx);
      push_word(st, KIND_READ, 8'h00, 8'h00, 32'h0, idx);
    endfunction

    function void hunt(logic [7:0] b);
      ph = (b == MAGIC_A) ? PH_HUNT2 : PH_HUNT1;
    endfunction

    function void end_frame();
      ph = (bytes_left == 0) ? PH_HUNT1 : PH_SKIP;
    endfunction

    // Advance the parser by one stream byte.
    function void take_byte(logic [7:0] b);
      logic [15:0] total;
      logic [2:0]  need;
      logic [7:0]  idx;
      case (ph)
        PH_HUNT1: hunt(b);
        PH_HUNT2: begin
          if (b == MAGIC_B) ph = PH_COUNT;
          else hunt(b);
        end
        PH_COUNT: begin
          owed = b;
          ph   = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len_lo = b;
          ph     = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          total     = {b, len_lo};
          cmd_count = '0;
          if (total < 16'(HEADER_LEN)) begin
            bytes_left = '0;
            ph         = PH_HUNT1;
            push_error(ST_BAD_LEN, 8'h00);
          end else begin
            bytes_left = total - 16'(HEADER_LEN);
            if (owed == 0) begin
              end_frame();
            end else if (bytes_left == 0) begin
              ph = PH_HUNT1;
              push_error(ST_TRUNCATED, 8'h00);
            end else begin
              ph = PH_OPCODE;
            end
          end
        end
        PH_OPCODE: begin
          if (bytes_left != 0) bytes_left--;
          if (b == codes.read_code) kind = KIND_READ;
          else if (b == codes.write_code) kind = KIND_WRITE;
          else if (b == codes.reset_code) kind = KIND_RESET;
          else begin
            end_frame();
            push_error(ST_BAD_OP, cmd_count);
            return;
          end
          pos  = '0;
          ser  = '0;
          addr = '0;
          data = '0;
          if (bytes_left == 0) begin
            ph = PH_HUNT1;
            push_error(ST_TRUNCATED, cmd_count);
          end else begin
            ph = PH_BODY;
          end
        end
        PH_BODY: begin
          if (bytes_left != 0) bytes_left--;
          if (pos == 3'd0) ser = b;
          else if (pos == 3'd1) addr = b;
          else if (pos < 3'd2 + DATA_BYTES) data |= 32'(b) << (8 * (pos - 3'd2));
          pos  = pos + 3'd1;
          need = (kind == KIND_WRITE) ? 3'd2 + DATA_BYTES : (kind == KIND_READ) ? 3'd2 : 3'd1;
          if (pos >= need) begin
            idx       = cmd_count;
            cmd_count = cmd_count + 8'd1;
            if (cmd_count == owed) end_frame();
            else if (bytes_left == 0) ph = PH_TRUNC;
            else ph = PH_OPCODE;
            if (kind == KIND_WRITE) push_word(ST_OK, KIND_WRITE, ser, addr, data, idx);
            else if (kind == KIND_READ) push_word(ST_OK, KIND_READ, ser, addr, 32'h0, idx);
            else push_word(ST_OK, KIND_RESET, ser, 8'h00, 32'h0, idx);
          end else if (bytes_left == 0) begin
            ph = PH_HUNT1;
            push_error(ST_TRUNCATED, cmd_count);
          end
        end
        PH_SKIP: begin
          if (bytes_left != 0) bytes_left--;
          if (bytes_left == 0) ph = PH_HUNT1;
        end
        PH_TRUNC: begin
          hunt(b);
          push_error(ST_TRUNCATED, cmd_count);
        end
        default: hunt(b);
      endcase
    endfunction

    function void cmp(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void match_word(result_t got);
      result_t want;
      if (expected_words.size() == 0) begin
        $error("unexpected result word: status %0d index %0d", got.status, got.command_index);
        errors++;
        return;
      end
      want = expected_words.pop_front();
      cmp("status", 32'(want.status), 32'(got.status));
      cmp("command_kind", 32'(want.command_kind), 32'(got.command_kind));
      cmp("serial_tag", 32'(want.serial_tag), 32'(got.serial_tag));
      cmp("target_addr", 32'(want.target_addr), 32'(got.target_addr));
      cmp("write_data", want.write_data, got.write_data);
      cmp("command_index", 32'(want.command_index), 32'(got.command_index));
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_wen   = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data  = '0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [1:0]  command_kind;
  logic [7:0]  serial_tag;
  logic [7:0]  target_addr;
  logic [31:0] write_data;
  logic [7:0]  command_index;

  frame_scoreboard sb;
  codes_t          opcodes;       // opcode values the frame builder encodes with
  logic [7:0]      frame_q[$];    // bytes of the frame under construction
  int              send_idle;     // sender idle chance per cycle, percent
  int              recv_idle;     // receiver stall chance per cycle, percent
  int              hold_req  = 0; // long receiver hold-off, handed to the receiver
  int              hold_left = 0;
  int              bytes_sent     = 0;
  int              frames_sent    = 0;
  int              settings_used  = 1;

  command_frame_parser DUT (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver: take a word whenever valid is high and stall was low at this
  // edge, then pick the stall for the next cycle. A hold-off request pins
  // stall high until its count, kept here, runs out.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.match_word({status, command_kind, serial_tag, target_addr, write_data, command_index});
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (int'($urandom_range(0, 99)) < recv_idle);
    end
  end

  // Bias random bytes toward the extremes now and then.
  function automatic logic [7:0] rnd_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom());
    endcase
  endfunction

  function automatic void add_header(input logic [7:0] count, input logic [15:0] len);
    frame_q.push_back(MAGIC_A);
    frame_q.push_back(MAGIC_B);
    frame_q.push_back(count);
    frame_q.push_back(len[7:0]);
    frame_q.push_back(len[15:8]);
  endfunction

  function automatic void add_command(input logic [1:0] k, input logic [7:0] s,
                                      input logic [7:0] a, input logic [31:0] d);
    case (k)
      KIND_READ:  frame_q.push_back(opcodes.read_code);
      KIND_WRITE: frame_q.push_back(opcodes.write_code);
      KIND_RESET: frame_q.push_back(opcodes.reset_code);
      default:    frame_q.push_back(rnd_byte());
    endcase
    frame_q.push_back(s);
    if (k == KIND_READ || k == KIND_WRITE) frame_q.push_back(a);
    if (k == KIND_WRITE)
      for (int i = 0; i < DATA_BYTES; i++) frame_q.push_back(d[8*i +: 8]);
  endfunction

  // Offer one byte and hold it until accepted; random idle cycles go in
  // front of it. Lower valid only on a cycle that starts an idle stretch.
  task automatic send_byte(input logic [7:0] b);
    if (int'($urandom_range(0, 99)) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (int'($urandom_range(0, 99)) < send_idle);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    sb.take_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frame_q();
    foreach (frame_q[i]) send_byte(frame_q[i]);
  endtask

  // Drop valid, wait for every predicted word, then let the pipeline settle.
  task automatic drain_out();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all three opcode registers, one per cycle, while the block is idle.
  task automatic load_codes(input logic [7:0] rd, input logic [7:0] wr, input logic [7:0] rs);
    logic [1:0] regs [3];
    logic [7:0] vals [3];
    regs = '{REG_READ_CODE, REG_WRITE_CODE, REG_RESET_CODE};
    vals = '{rd, wr, rs};
    for (int i = 0; i < 3; i++) begin
      cfg_wen   <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      sb.set_code(regs[i], vals[i]);
    end
    cfg_wen <= 1'b0;
    opcodes = '{read_code: rd, write_code: wr, reset_code: rs};
    settings_used++;
  endtask

  // Build and send one random frame. Many are well formed with random
  // content; the rest run out of bytes, owe more or fewer commands than they
  // carry, pad the tail, give a bad length, carry stray opcodes or are noise.
  task automatic send_random_frame();
    int          n_cmd;
    int          owed;
    int          body_len;
    int          total;
    int          pad;
    int          variant;
    int          count_at;
    logic [1:0]  k;
    frame_q.delete();
    variant = $urandom_range(0, 15);
    if (variant == 15) begin
      // pure line noise
      repeat ($urandom_range(3, 10)) frame_q.push_back(rnd_byte());
    end else begin
      if ($urandom_range(0, 7) == 0)
        repeat ($urandom_range(1, 4)) frame_q.push_back(rnd_byte());
      if ($urandom_range(0, 5) == 0) frame_q.push_back(MAGIC_A);
      add_header(8'h00, 16'h0000);
      count_at = frame_q.size() - 3;
      n_cmd    = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 6);
      for (int i = 0; i < n_cmd; i++) begin
        k = ($urandom_range(0, 15) == 0) ? KIND_STRAY : 2'($urandom_range(0, 2));
        add_command(k, rnd_byte(), rnd_byte(), {rnd_byte(), rnd_byte(), rnd_byte(), rnd_byte()});
      end
      body_len = frame_q.size() - count_at - 3;
      owed     = n_cmd;
      total    = body_len + HEADER_LEN;
      case (variant)
        0, 1: owed = n_cmd + $urandom_range(1, 2);
        2:    owed = (n_cmd > 1) ? $urandom_range(1, n_cmd - 1) : 0;
        3, 4: if (body_len > 0) total = HEADER_LEN + $urandom_range(0, body_len - 1);
        5: begin
          pad   = $urandom_range(1, 6);
          total = total + pad;
          repeat (pad) frame_q.push_back(rnd_byte());
        end
        6: total = $urandom_range(0, HEADER_LEN - 1);
        7: begin
          // long tail that pushes the length past one byte
          if ($urandom_range(0, 3) == 0) begin
            pad   = $urandom_range(250, 300);
            total = total + pad;
            repeat (pad) frame_q.push_back(rnd_byte());
          end
        end
        default: ;
      endcase
      frame_q[count_at]     = 8'(owed);
      frame_q[count_at + 1] = total[7:0];
      frame_q[count_at + 2] = total[15:8];
    end
    send_frame_q();
    frames_sent++;
  endtask

  task automatic run_phase(input int n_bytes);
    int stop_at;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) send_random_frame();
    drain_out();
  endtask

  initial begin
    sb        = new();
    opcodes   = '{read_code: 8'h00, write_code: 8'h01, reset_code: 8'h02};
    send_idle = 33;
    recv_idle = 88;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed frames at the reset opcodes. Lead with a doubled first magic
    // byte; the first frame owes four commands but carries three (reset,
    // read, write at the extremes), so the next byte, which opens the
    // following header, reports truncation and is also hunted.
    frame_q.delete();
    frame_q.push_back(MAGIC_A);
    add_header(8'd4, 16'd17);
    add_command(KIND_RESET, 8'hFF, 8'h00, 32'h0);
    add_command(KIND_READ, 8'h00, 8'hFF, 32'h0);
    add_command(KIND_WRITE, 8'hFF, 8'h00, 32'hFFFF_FFFF);
    add_header(8'd1, 16'd4);        // length below the header size
    add_header(8'd1, 16'd6);        // unknown opcode
    frame_q.push_back(8'h33);
    add_header(8'd1, 16'd5);        // empty body with a command owed
    add_header(8'd0, 16'd6);        // nothing owed: skip the body
    frame_q.push_back(8'hAB);
    add_header(8'd1, 16'd7);        // frame ends inside a read
    add_command(KIND_READ, 8'h11, 8'h22, 32'h0);
    void'(frame_q.pop_back());
    send_frame_q();
    drain_out();

    // Back-pressure: hold the receiver off for a long stretch while a frame
    // of short commands streams in, so the output fills and input stalls.
    frame_q.delete();
    add_header(8'd24, 16'(HEADER_LEN + 24 * 2));
    repeat (24) add_command(KIND_RESET, rnd_byte(), 8'h00, 32'h0);
    hold_req = 150;
    send_frame_q();
    drain_out();

    run_phase(300);

    send_idle = 88;
    recv_idle = 33;
    load_codes(MAGIC_A, MAGIC_B, 8'h80);
    run_phase(300);

    // No idling from here on; overlapping opcodes test decode priority.
    send_idle = 0;
    recv_idle = 0;
    load_codes(8'h5A, 8'h5A, 8'h5A);
    run_phase(250);
    load_codes(8'hFF, 8'h00, 8'h00);
    run_phase(500);

    $display("run covered %0d stream bytes in %0d random frames under %0d opcode settings",
             bytes_sent, frames_sent, settings_used);
    $display("matched %0d command words and %0d error words", sb.ok_words, sb.err_words);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
